FILE: design/sct_pkg.sv
package sct_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_LAT = 4 + CORDIC_ITERATIONS + 1;
    localparam int DIV_W = 25;
    localparam int POST_LAT = 5;
    localparam int PIPE_LAT = CORDIC_LAT + POST_LAT + DIV_W;

    localparam int ANG_W = 18;
    localparam int DIST_W = 16;
    localparam int PT_W = 22;
    localparam int TRIG_W = 32;
    localparam int OFS_W = 16;
    localparam int SDIV_W = 8;
    localparam int LIM_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT    = 2'd2;

    localparam logic [OFS_W-1:0]  RST_CENTER_OFFSET = 16'd2000;
    localparam logic [SDIV_W-1:0] RST_SCALE_DIVISOR = 8'd10;
    localparam logic [LIM_W-1:0]  RST_KEEP_LIMIT    = 16'd500;

    localparam logic signed [18:0] ANG_TURN = 19'sd92160;
    localparam logic signed [18:0] ANG_TWO_TURNS = 19'sd184320;
    localparam logic [17:0] RECIP_45 = 18'd186413;
    localparam logic [27:0] RECIP_45_FINE = 28'd190887436;
    localparam logic signed [32:0] INV_GAIN = 33'sd652032874;

    localparam logic signed [PT_W-1:0] OUT_MAX = 22'sd2097151;
    localparam logic signed [PT_W-1:0] OUT_MIN = -22'sd2097152;

    typedef logic [31:0] t_atan_tab [0:23];

    localparam t_atan_tab ATAN_TAB = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

FILE: design/sct_cordic.sv
module sct_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [sct_pkg::ANG_W-1:0]     i_angle,
    output logic signed [sct_pkg::TRIG_W-1:0]    o_cos,
    output logic signed [sct_pkg::TRIG_W-1:0]    o_sin
);
    import sct_pkg::*;

    localparam int N = CORDIC_ITERATIONS;

    logic [16:0] r_a1;
    logic [16:0] r_a2;
    logic [10:0] r_k0;
    logic [10:0] r_k3;
    logic [26:0] r_x3;

    logic signed [32:0] r_cx [0:N];
    logic signed [32:0] r_cy [0:N];
    logic signed [31:0] r_cz [0:N];
    logic [1:0]         r_cq [0:N];

    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;

    logic signed [18:0] n_a;
    logic [34:0] n_kprod;
    logic [16:0] n_r17;
    logic [6:0]  n_r0;
    logic        n_ge;
    logic [5:0]  n_r;
    logic [54:0] n_phprod;
    logic [31:0] n_ph;

    always_comb begin
        n_a = {i_angle[ANG_W-1], i_angle};
        if (n_a >= ANG_TURN) begin
            n_a = n_a - ANG_TURN;
        end else if (n_a < -ANG_TURN) begin
            n_a = n_a + ANG_TWO_TURNS;
        end else if (n_a < 19'sd0) begin
            n_a = n_a + ANG_TURN;
        end
    end

    assign n_kprod  = r_a1 * RECIP_45;
    assign n_r17    = r_a2 - 17'(r_k0) * 17'd45;
    assign n_r0     = n_r17[6:0];
    assign n_ge     = (n_r0 >= 7'd45);
    assign n_r      = n_ge ? 6'(n_r0 - 7'd45) : n_r0[5:0];
    assign n_phprod = r_x3 * RECIP_45_FINE;
    assign n_ph     = {r_k3, n_phprod[53:33]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= n_a[16:0];
            r_a2 <= r_a1;
            r_k0 <= n_kprod[33:23];
            r_k3 <= r_k0 + 11'(n_ge);
            r_x3 <= {n_r, 21'd0} + 27'd22;
            r_cx[0] <= INV_GAIN;
            r_cy[0] <= '0;
            r_cz[0] <= {2'b00, n_ph[29:0]};
            r_cq[0] <= n_ph[31:30];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cz[g][31]) begin
                    r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] - $signed(ATAN_TAB[g]);
                end else begin
                    r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                    r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                    r_cz[g+1] <= r_cz[g] + $signed(ATAN_TAB[g]);
                end
                r_cq[g+1] <= r_cq[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_cq[N])
                2'd0: begin
                    r_cos <= r_cx[N][TRIG_W-1:0];
                    r_sin <= r_cy[N][TRIG_W-1:0];
                end
                2'd1: begin
                    r_cos <= -r_cy[N][TRIG_W-1:0];
                    r_sin <= r_cx[N][TRIG_W-1:0];
                end
                2'd2: begin
                    r_cos <= -r_cx[N][TRIG_W-1:0];
                    r_sin <= -r_cy[N][TRIG_W-1:0];
                end
                default: begin
                    r_cos <= r_cy[N][TRIG_W-1:0];
                    r_sin <= -r_cx[N][TRIG_W-1:0];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

FILE: design/sct_div.sv
module sct_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [sct_pkg::DIV_W-1:0]       i_num,
    input  logic [sct_pkg::SDIV_W-1:0]      i_div,
    input  logic                            i_neg,
    output logic [sct_pkg::DIV_W-1:0]       o_quo,
    output logic                            o_neg
);
    import sct_pkg::*;

    logic [SDIV_W-1:0] r_rem [0:DIV_W];
    logic [DIV_W-1:0]  r_qw  [0:DIV_W];
    logic              r_neg [0:DIV_W];

    assign r_rem[0] = '0;
    assign r_qw[0]  = i_num;
    assign r_neg[0] = i_neg;

    for (genvar g = 0; g < DIV_W; g++) begin : g_step
        logic [SDIV_W:0] n_t;
        logic            n_ge;

        assign n_t  = {r_rem[g], r_qw[g][DIV_W-1]};
        assign n_ge = (n_t >= {1'b0, i_div});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= n_ge ? SDIV_W'(n_t - {1'b0, i_div}) : n_t[SDIV_W-1:0];
                r_qw[g+1]  <= {r_qw[g][DIV_W-2:0], n_ge};
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    assign o_quo = r_qw[DIV_W];
    assign o_neg = r_neg[DIV_W];

endmodule

FILE: design/spherical_to_cartesian_filter_top.sv
// Spherical to Cartesian point filter. Each request carries elevation and azimuth in
// degrees (signed Q10.8, any value, reduced modulo 360) and a range; the block returns
// x = d*cos(el)*cos(az), y = d*cos(el)*sin(az), z = d*sin(el), each offset by
// center_offset, divided by scale_divisor (0 acts as 1), rounded and saturated to
// 22 bits with 4 fraction bits. A point whose x or y is not below keep_limit is
// dropped and produces no result. One request enters every cycle while the output is
// not stalled; each passes through the 21-stage CORDIC rotator (16 iterations)
// and the 25-stage bit-per-stage divider. A stalled output holds the whole pipeline.
// The user must write registers via the configuration port only while idle (not enforced).
module spherical_to_cartesian_filter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [sct_pkg::ANG_W-1:0]      i_elevation_angle,
    input  logic signed [sct_pkg::ANG_W-1:0]      i_azimuth_angle,
    input  logic [sct_pkg::DIST_W-1:0]            i_distance,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [sct_pkg::PT_W-1:0]       o_point_x,
    output logic signed [sct_pkg::PT_W-1:0]       o_point_y,
    output logic signed [sct_pkg::PT_W-1:0]       o_point_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sct_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sct_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sct_pkg::*;

    logic en;

    logic [OFS_W-1:0]  r_center_offset;
    logic [SDIV_W-1:0] r_scale_divisor;
    logic [LIM_W-1:0]  r_keep_limit;
    logic [SDIV_W-1:0] n_div;

    logic r_vld [0:PIPE_LAT-1];
    logic [DIST_W-1:0] r_dist [0:CORDIC_LAT+1];

    logic signed [TRIG_W-1:0] ce, se, ca, sa;

    logic signed [63:0] r_pxp, r_pyp;
    logic signed [TRIG_W-1:0] r_se1, r_se2;
    logic signed [TRIG_W-1:0] r_mx, r_my;
    logic signed [63:0] n_rx, n_ry;

    logic signed [48:0] r_cx, r_cy, r_cz;
    logic [49:0] r_mag [0:2];
    logic        r_neg [0:2];
    logic [DIV_W-1:0] r_w [0:2];
    logic             r_wneg [0:2];

    logic [DIV_W-1:0] quo [0:2];
    logic             qneg [0:2];
    logic signed [PT_W-1:0] n_pt [0:2];
    logic signed [PT_W-1:0] n_lim;
    logic n_keep;

    logic signed [PT_W-1:0] r_px, r_py, r_pz;
    logic r_out_valid;

    assign en = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign o_cfg_ready = 1'b1;
    assign n_div = (r_scale_divisor == '0) ? SDIV_W'(1) : r_scale_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_offset <= RST_CENTER_OFFSET;
            r_scale_divisor <= RST_SCALE_DIVISOR;
            r_keep_limit    <= RST_KEEP_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_OFFSET: r_center_offset <= i_cfg_data;
                REG_SCALE_DIVISOR: r_scale_divisor <= i_cfg_data[SDIV_W-1:0];
                REG_KEEP_LIMIT:    r_keep_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_valid <= r_vld[PIPE_LAT-1] && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist[0] <= i_distance;
            for (int i = 1; i < CORDIC_LAT + 2; i++) begin
                r_dist[i] <= r_dist[i-1];
            end
        end
    end

    sct_cordic u_cordic_el (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_elevation_angle),
        .o_cos   (ce),
        .o_sin   (se)
    );

    sct_cordic u_cordic_az (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_azimuth_angle),
        .o_cos   (ca),
        .o_sin   (sa)
    );

    assign n_rx = r_pxp + 64'sd536870912;
    assign n_ry = r_pyp + 64'sd536870912;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxp <= ce * ca;
            r_pyp <= ce * sa;
            r_se1 <= se;
            r_mx  <= n_rx[61:30];
            r_my  <= n_ry[61:30];
            r_se2 <= r_se1;
            r_cx  <= $signed({1'b0, r_dist[CORDIC_LAT+1]}) * r_mx;
            r_cy  <= $signed({1'b0, r_dist[CORDIC_LAT+1]}) * r_my;
            r_cz  <= $signed({1'b0, r_dist[CORDIC_LAT+1]}) * r_se2;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [48:0] n_c;
        logic signed [49:0] n_num;
        logic [54:0] n_n;

        assign n_c = (g == 0) ? r_cx : (g == 1) ? r_cy : r_cz;
        assign n_num = {n_c[48], n_c} + $signed({4'b0, r_center_offset, 30'd0});
        assign n_n = {1'b0, r_mag[g], 4'd0} + {18'd0, n_div, 29'd0};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_neg[g]  <= n_num[49];
                r_mag[g]  <= n_num[49] ? 50'(-n_num) : n_num;
                r_w[g]    <= n_n[54:30];
                r_wneg[g] <= r_neg[g];
            end
        end

        sct_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_w[g]),
            .i_div (n_div),
            .i_neg (r_wneg[g]),
            .o_quo (quo[g]),
            .o_neg (qneg[g])
        );

        always_comb begin
            if (qneg[g]) begin
                n_pt[g] = (quo[g] > DIV_W'(2097152)) ? OUT_MIN : -$signed(quo[g][PT_W-1:0]);
            end else begin
                n_pt[g] = (quo[g] > DIV_W'(2097151)) ? OUT_MAX : $signed(quo[g][PT_W-1:0]);
            end
        end
    end

    assign n_lim  = $signed({2'b00, r_keep_limit, 4'd0});
    assign n_keep = (n_pt[0] < n_lim) && (n_pt[1] < n_lim);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= n_pt[0];
            r_py <= n_pt[1];
            r_pz <= n_pt[2];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_point_z = r_pz;

endmodule
